// File: rtl/core/bn12_pkg.sv
// Shared types, constants and helpers for the BGR to NV12 converter.
package bn12_pkg;

   // Field widths
   localparam int CFG_W      = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int PIX_W      = 8;
   localparam int LADDR_W    = 24;
   localparam int CADDR_W    = 25;
   localparam int Q_SUM_W    = 26;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // Q16 color matrix (analog YUV)
   localparam logic signed [Q_SUM_W-1:0] C_YR = 26'sd19595;
   localparam logic signed [Q_SUM_W-1:0] C_YG = 26'sd38470;
   localparam logic signed [Q_SUM_W-1:0] C_YB = 26'sd7471;
   localparam logic signed [Q_SUM_W-1:0] C_UR = -26'sd9634;
   localparam logic signed [Q_SUM_W-1:0] C_UG = -26'sd18940;
   localparam logic signed [Q_SUM_W-1:0] C_UB = 26'sd28574;
   localparam logic signed [Q_SUM_W-1:0] C_VR = 26'sd40305;
   localparam logic signed [Q_SUM_W-1:0] C_VG = -26'sd33751;
   localparam logic signed [Q_SUM_W-1:0] C_VB = -26'sd6554;
   localparam logic signed [Q_SUM_W-1:0] C_OFS = 26'sd8388608;   // 128 in Q16

   // Raster position of one pixel, as seen by the output stage
   typedef struct packed {
      logic [LADDR_W-1:0] pixel_index;
      logic [LADDR_W-1:0] chroma_offset;   // (row/2)*(W/2) + col/2
      logic               frame_end;
   } pos_type;

   // Negative gives 0, else truncate Q16 and saturate to 255
   function automatic logic [PIX_W-1:0] clamp_q16(input logic signed [Q_SUM_W-1:0] s);
      logic [PIX_W-1:0] res;
      if (s[Q_SUM_W-1]) begin
         res = '0;
      end else if (|s[Q_SUM_W-2:16+PIX_W]) begin
         res = '1;
      end else begin
         res = s[16+PIX_W-1:16];
      end
      return res;
   endfunction

endpackage

// File: rtl/core/bn12_req_if.sv
// Pixel request channel: one packed BGR pixel per transaction.
interface bn12_req_if
   import bn12_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] blue;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] red;

   modport source (output valid, blue, green, red, input ready);
   modport sink   (input valid, blue, green, red, output ready);
endinterface

// File: rtl/core/bn12_rsp_if.sv
// Result channel: luma and chroma bytes with their NV12 byte addresses.
interface bn12_rsp_if
   import bn12_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [PIX_W-1:0]   luma;
   logic [LADDR_W-1:0] luma_addr;
   logic [PIX_W-1:0]   chroma_u;
   logic [PIX_W-1:0]   chroma_v;
   logic [CADDR_W-1:0] chroma_addr;
   logic               frame_end;

   modport source (output valid, luma, luma_addr, chroma_u, chroma_v, chroma_addr,
                   frame_end, input ready);
   modport sink   (input valid, luma, luma_addr, chroma_u, chroma_v, chroma_addr,
                   frame_end, output ready);
endinterface

// File: rtl/core/bn12_csc.sv
// Color space conversion: BGR bytes to clamped Y, U, V with constant Q16 multiplies.
module bn12_csc
   import bn12_pkg::*;
(
   input  logic [PIX_W-1:0] blue,
   input  logic [PIX_W-1:0] green,
   input  logic [PIX_W-1:0] red,
   output logic [PIX_W-1:0] luma,
   output logic [PIX_W-1:0] chroma_u,
   output logic [PIX_W-1:0] chroma_v
);

   logic signed [Q_SUM_W-1:0] b_s, g_s, r_s;
   logic signed [Q_SUM_W-1:0] y_sum, u_sum, v_sum;

   // zero-extend the components into the signed sum width
   assign b_s = $signed({{(Q_SUM_W-PIX_W){1'b0}}, blue});
   assign g_s = $signed({{(Q_SUM_W-PIX_W){1'b0}}, green});
   assign r_s = $signed({{(Q_SUM_W-PIX_W){1'b0}}, red});

   // matrix rows; every product is by a constant
   assign y_sum = C_YR * r_s + C_YG * g_s + C_YB * b_s;
   assign u_sum = C_OFS + C_UR * r_s + C_UG * g_s + C_UB * b_s;
   assign v_sum = C_OFS + C_VR * r_s + C_VG * g_s + C_VB * b_s;

   assign luma     = clamp_q16(y_sum);
   assign chroma_u = clamp_q16(u_sum);
   assign chroma_v = clamp_q16(v_sum);

endmodule

// File: rtl/core/bn12_addr.sv
// Raster position tracker: column, row, luma index and chroma row base.
module bn12_addr
   import bn12_pkg::*;
#(
   parameter int CNT_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,        // configuration write restarts the frame
   input  logic             advance,      // pixel transaction accepted
   input  logic [CFG_W-1:0] frame_width,  // effective width, 1..MAX_DIM
   input  logic [CFG_W-1:0] frame_height, // effective height, 1..MAX_DIM
   output pos_type          pos
);

   localparam int CMP_W = CFG_W + 1;

   logic [CNT_W-1:0]   column_ff, column_in;
   logic [CNT_W-1:0]   row_ff, row_in;
   logic [LADDR_W-1:0] pixel_index_ff, pixel_index_in;
   logic [LADDR_W-1:0] chroma_base_ff, chroma_base_in;
   logic               last_col, last_row;

   assign last_col = (CMP_W'(column_ff) + CMP_W'(1)) >= CMP_W'(frame_width);
   assign last_row = (CMP_W'(row_ff) + CMP_W'(1)) >= CMP_W'(frame_height);

   // position of the pixel now at the input
   assign pos.pixel_index   = pixel_index_ff;
   assign pos.chroma_offset = chroma_base_ff + LADDR_W'(column_ff >> 1);
   assign pos.frame_end     = last_col && last_row;

   // next position
   always_comb begin
      column_in      = column_ff;
      row_in         = row_ff;
      pixel_index_in = pixel_index_ff;
      chroma_base_in = chroma_base_ff;
      if (clear || (advance && last_col && last_row)) begin
         column_in      = '0;
         row_in         = '0;
         pixel_index_in = '0;
         chroma_base_in = '0;
      end else if (advance) begin
         pixel_index_in = pixel_index_ff + LADDR_W'(1);
         if (last_col) begin
            column_in = '0;
            row_in    = row_ff + CNT_W'(1);
            // moving onto an even row starts a new chroma row
            if (row_ff[0]) begin
               chroma_base_in = chroma_base_ff + LADDR_W'(frame_width >> 1);
            end
         end else begin
            column_in = column_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff      <= '0;
         row_ff         <= '0;
         pixel_index_ff <= '0;
         chroma_base_ff <= '0;
      end else begin
         column_ff      <= column_in;
         row_ff         <= row_in;
         pixel_index_ff <= pixel_index_in;
         chroma_base_ff <= chroma_base_in;
      end
   end

   // column and row stay inside the frame
   a_column_in_frame: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(column_ff) < CMP_W'(frame_width))
      else $error("column count outside frame width");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(row_ff) < CMP_W'(frame_height))
      else $error("row count outside frame height");

   // the last pixel of a frame wraps the position back to the origin
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      advance && pos.frame_end |=> column_ff == '0 && row_ff == '0 &&
                                   pixel_index_ff == '0 && chroma_base_ff == '0)
      else $error("position not cleared after frame end");

endmodule

// File: rtl/core/bgr_to_nv12_converter.sv
// Top level of the BGR to NV12 converter: config registers and two-stage pipeline.
//
// Usage:
//   req_chan carries one packed pixel (blue, green, red) per transaction, in raster
//   order over a frame of frame_width x frame_height pixels. rsp_chan returns one
//   result per pixel: the luma byte with its NV12 byte address, and U/V with the
//   address of the interleaved chroma pair of the pixel's 2x2 block (every pixel
//   writes its chroma, so the last pixel of a block wins). frame_end marks the
//   last pixel of the frame.
//   csr_wr_en/csr_index/csr_wdata write frame_width (0) and frame_height (1); a
//   write restarts the frame at the origin. Zero acts as 1, above MAX_DIM as MAX_DIM.
//   Write them only while no transaction is in flight.
// Timing:
//   The input stage holds the accepted pixel and its position, the output register
//   holds the converted result and drives rsp_chan.valid; a pixel passes through
//   both registers in that order. Throughput is one pixel per cycle while
//   rsp_chan.ready stays high; conversion is constant multiplies and the frame
//   size is one 13x13 multiply, all ahead of the output register.
// Reset: sets width 640, height 480, clears the position and empties both stages.
// Stall: while rsp_chan.ready is low the result holds; the input stage still takes
//   one more pixel, then req_chan.ready drops until the output drains.
module bgr_to_nv12_converter
   import bn12_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   bn12_req_if.sink             req_chan,
   bn12_rsp_if.source           rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_DIM);
   localparam int PROD_W = 2 * CFG_W;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [CFG_W-1:0] width_eff, height_eff;
   logic             cfg_clear;

   logic             out_free, s1_adv, accept;
   pos_type          pos;

   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_blue_ff, s1_green_ff, s1_red_ff;
   pos_type          s1_pos_ff;

   logic [PIX_W-1:0]  luma_in, chroma_u_in, chroma_v_in;
   logic [PROD_W-1:0] frame_size;
   logic [CADDR_W-1:0] chroma_addr_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   luma_ff, chroma_u_ff, chroma_v_ff;
   logic [LADDR_W-1:0] luma_addr_ff;
   logic [CADDR_W-1:0] chroma_addr_ff;
   logic               frame_end_ff;

   // Register write decode
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      cfg_clear = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH: begin
               width_in  = csr_wdata;
               cfg_clear = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = csr_wdata;
               cfg_clear = 1'b1;
            end
            default: begin
               cfg_clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Effective dimensions: zero acts as one, oversize clamps to MAX_DIM
   assign width_eff  = (width_ff == '0) ? CFG_W'(1) :
                       ({1'b0, width_ff} > (CFG_W+1)'(MAX_DIM)) ? CFG_W'(MAX_DIM) : width_ff;
   assign height_eff = (height_ff == '0) ? CFG_W'(1) :
                       ({1'b0, height_ff} > (CFG_W+1)'(MAX_DIM)) ? CFG_W'(MAX_DIM) : height_ff;

   // Handshake: both stages move when the stage ahead has room
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   bn12_addr #(
      .CNT_W (CNT_W)
   ) u_addr (
      .clock        (clock),
      .reset        (reset),
      .clear        (cfg_clear),
      .advance      (accept),
      .frame_width  (width_eff),
      .frame_height (height_eff),
      .pos          (pos)
   );

   // Input stage
   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_blue_ff  <= req_chan.blue;
         s1_green_ff <= req_chan.green;
         s1_red_ff   <= req_chan.red;
         s1_pos_ff   <= pos;
      end
   end

   // Conversion and chroma address for the output stage
   bn12_csc u_csc (
      .blue     (s1_blue_ff),
      .green    (s1_green_ff),
      .red      (s1_red_ff),
      .luma     (luma_in),
      .chroma_u (chroma_u_in),
      .chroma_v (chroma_v_in)
   );

   assign frame_size     = PROD_W'(width_eff) * PROD_W'(height_eff);
   assign chroma_addr_in = CADDR_W'(frame_size) + {s1_pos_ff.chroma_offset, 1'b0};

   // Output register
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_adv) begin
         luma_ff        <= luma_in;
         luma_addr_ff   <= s1_pos_ff.pixel_index;
         chroma_u_ff    <= chroma_u_in;
         chroma_v_ff    <= chroma_v_in;
         chroma_addr_ff <= chroma_addr_in;
         frame_end_ff   <= s1_pos_ff.frame_end;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.luma        = luma_ff;
   assign rsp_chan.luma_addr   = luma_addr_ff;
   assign rsp_chan.chroma_u    = chroma_u_ff;
   assign rsp_chan.chroma_v    = chroma_v_ff;
   assign rsp_chan.chroma_addr = chroma_addr_ff;
   assign rsp_chan.frame_end   = frame_end_ff;

   // an accepted pixel always lands in the input stage
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transaction lost at input stage");

   // a blocked input stage keeps its pixel and position
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_pos_ff) &&
                                   $stable(s1_blue_ff))
      else $error("input stage changed while blocked");

   // a pixel leaving the input stage shows up as a result
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("result missing after input stage advance");

endmodule
